[rtl/scfp_pkg.sv]
package scfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int EVENT_W    = 4;
  localparam int CMD_NUM    = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_START = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_START = 4'd1;

  // reset values of the start bytes ('#' and '&')
  localparam logic [BYTE_W-1:0] CONTROL_START_RST = 8'd35;
  localparam logic [BYTE_W-1:0] COMMAND_START_RST = 8'd38;

  typedef enum logic [EVENT_W-1:0] {
    EV_SET       = 4'd0,
    EV_CK_ERR    = 4'd1,
    EV_DBG_ON    = 4'd2,
    EV_DBG_OFF   = 4'd3,
    EV_DEACT     = 4'd4,
    EV_STOP_LINK = 4'd5,
    EV_START     = 4'd6,
    EV_STOP      = 4'd7,
    EV_UNKNOWN   = 4'd8
  } event_t;

  typedef struct packed {
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    event_t            ev;
  } cmd_entry_t;

  localparam cmd_entry_t CMD_TABLE [CMD_NUM] = '{
    '{a: 8'd38, b: 8'd79, c: 8'd123, ev: EV_DBG_ON},
    '{a: 8'd31, b: 8'd39, c: 8'd115, ev: EV_DBG_OFF},
    '{a: 8'd67, b: 8'd89, c: 8'd23,  ev: EV_DEACT},
    '{a: 8'd34, b: 8'd63, c: 8'd129, ev: EV_STOP_LINK},
    '{a: 8'd25, b: 8'd45, c: 8'd65,  ev: EV_START},
    '{a: 8'd13, b: 8'd26, c: 8'd39,  ev: EV_STOP}
  };

endpackage

[rtl/scfp_if.sv]
interface scfp_in_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfp_out_if;
  import scfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [BYTE_W-1:0]  speed;
  logic [BYTE_W-1:0]  steer;
  logic               debug_enabled;

  modport source (output valid, output event_res, output speed, output steer,
                  output debug_enabled, input ready);
  modport sink   (input valid, input event_res, input speed, input steer,
                  input debug_enabled, output ready);
endinterface

[rtl/scfp_cmd_decode.sv]
module scfp_cmd_decode (
  input  logic [scfp_pkg::BYTE_W-1:0] first_byte,
  input  logic [scfp_pkg::BYTE_W-1:0] second_byte,
  input  logic [scfp_pkg::BYTE_W-1:0] third_byte,
  output scfp_pkg::event_t            cmd_ev
);
  import scfp_pkg::*;

  // table entries are distinct; the lowest matching entry wins
  always_comb begin
    cmd_ev = EV_UNKNOWN;
    for (int i = CMD_NUM - 1; i >= 0; i--) begin
      if (CMD_TABLE[i].a == first_byte && CMD_TABLE[i].b == second_byte &&
          CMD_TABLE[i].c == third_byte) begin
        cmd_ev = CMD_TABLE[i].ev;
      end
    end
  end

endmodule

[rtl/serial_command_frame_parser.sv]
// Channel  | Dir | Payload                                   | Transaction when
// in_ch    | in  | rx_byte[7:0]                              | valid & ready
// out_ch   | out | event_res[3:0] speed[7:0] steer[7:0] dbg  | valid & ready
// cfg_*    | in  | cfg_index[3:0] cfg_data[7:0]              | cfg_wr_en
//
// One byte per cycle. A byte is parsed in the cycle it is taken; the frame's
// closing byte loads the result register, shown on out_ch the next cycle.
// Synchronous active-low reset: idle phase, debug on, start bytes '#'/'&'.
// in_ch.ready drops only while a result sits in the output register and
// out_ch.ready is low; a result taken that cycle lets the next byte in.
module serial_command_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  scfp_in_if.sink                         in_ch,
  scfp_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [scfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scfp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scfp_pkg::*;

  // Frame phase: CTLn / CMDn wait for payload byte n of a control or
  // command frame.
  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_CTL1 = 7'b0000010,
    PH_CTL2 = 7'b0000100,
    PH_CTL3 = 7'b0001000,
    PH_CMD1 = 7'b0010000,
    PH_CMD2 = 7'b0100000,
    PH_CMD3 = 7'b1000000
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] ctl_start_r;
  logic [BYTE_W-1:0] cmd_start_r;
  logic [BYTE_W-1:0] held_first_r, held_first_nxt;
  logic [BYTE_W-1:0] held_second_r, held_second_nxt;
  logic              debug_r, debug_nxt;

  // output register
  logic              out_valid_r;
  event_t            out_ev_r, out_ev_nxt;
  logic [BYTE_W-1:0] out_speed_r, out_speed_nxt;
  logic [BYTE_W-1:0] out_steer_r, out_steer_nxt;
  logic              out_debug_r;

  logic              in_fire;
  logic              res_fire;
  logic [BYTE_W-1:0] rx;
  logic [BYTE_W-1:0] check_sum;
  event_t            cmd_ev;

  assign rx          = in_ch.rx_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // speed + 2*steer, mod 256
  assign check_sum = held_first_r + {held_second_r[BYTE_W-2:0], 1'b0};

  scfp_cmd_decode u_cmd_decode (
    .first_byte  (held_first_r),
    .second_byte (held_second_r),
    .third_byte  (rx),
    .cmd_ev      (cmd_ev)
  );

  always_comb begin
    phase_nxt       = phase_r;
    held_first_nxt  = held_first_r;
    held_second_nxt = held_second_r;
    debug_nxt       = debug_r;
    res_fire        = 1'b0;
    out_ev_nxt      = EV_SET;
    out_speed_nxt   = '0;
    out_steer_nxt   = '0;
    if (in_fire) begin
      case (phase_r)
        PH_IDLE: begin
          // control start wins when both start bytes match
          if (rx == ctl_start_r) begin
            phase_nxt = PH_CTL1;
          end else if (rx == cmd_start_r) begin
            phase_nxt = PH_CMD1;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_CTL1: begin
          held_first_nxt = rx;
          phase_nxt      = PH_CTL2;
        end
        PH_CMD1: begin
          held_first_nxt = rx;
          phase_nxt      = PH_CMD2;
        end
        PH_CTL2: begin
          held_second_nxt = rx;
          phase_nxt       = PH_CTL3;
        end
        PH_CMD2: begin
          held_second_nxt = rx;
          phase_nxt       = PH_CMD3;
        end
        PH_CTL3: begin
          phase_nxt = PH_IDLE;
          res_fire  = 1'b1;
          if (check_sum == rx) begin
            out_ev_nxt    = EV_SET;
            out_speed_nxt = held_first_r;
            out_steer_nxt = held_second_r;
          end else begin
            out_ev_nxt = EV_CK_ERR;
          end
        end
        PH_CMD3: begin
          phase_nxt  = PH_IDLE;
          res_fire   = 1'b1;
          out_ev_nxt = cmd_ev;
          if (cmd_ev == EV_DBG_ON) begin
            debug_nxt = 1'b1;
          end else if (cmd_ev == EV_DBG_OFF) begin
            debug_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      debug_r     <= 1'b1;
      ctl_start_r <= CONTROL_START_RST;
      cmd_start_r <= COMMAND_START_RST;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      debug_r <= debug_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CONTROL_START: ctl_start_r <= cfg_data;
          CFG_COMMAND_START: cmd_start_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // held bytes and result payload: no reset needed
  always_ff @(posedge clk) begin
    held_first_r  <= held_first_nxt;
    held_second_r <= held_second_nxt;
    if (res_fire) begin
      out_ev_r    <= out_ev_nxt;
      out_speed_r <= out_speed_nxt;
      out_steer_r <= out_steer_nxt;
      out_debug_r <= debug_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_res     = out_ev_r;
  assign out_ch.speed         = out_speed_r;
  assign out_ch.steer         = out_steer_r;
  assign out_ch.debug_enabled = out_debug_r;

  // closing byte of a frame always produces a result next cycle
  a_close_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_CTL3 || phase_r == PH_CMD3) |=> out_valid_r)
    else $error("closing byte did not produce a result");

  // a non-closing byte never produces a result
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !(phase_r == PH_CTL3 || phase_r == PH_CMD3) && out_ch.ready
    |=> !out_valid_r)
    else $error("result without a closing byte");

  // checksum failures carry no speed or steer
  a_ck_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ev_r == EV_CK_ERR |-> out_speed_r == '0 && out_steer_r == '0)
    else $error("checksum error result with nonzero speed or steer");

  // reported debug flag matches the live flag while a result is shown
  a_debug_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_debug_r == debug_r)
    else $error("reported debug flag differs from the kept flag");

endmodule
